@@ rtl/core/nuvs_pkg.sv @@
// Package for the nearest unit-vector search block.
// Holds shared widths, request codes, parameter defaults and control types.
// No dependencies.
package nuvs_pkg;

    localparam int MAX_CELLS_DEF = 1024;
    localparam int MAX_K_DEF     = 8;

    localparam int POS_W   = 16;
    localparam int QUERY_W = 24;
    localparam int SQ_W    = 32;
    localparam int DIST_W  = 34;

    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_NEAREST = 2'd1;
    localparam logic [1:0] REQ_KNN     = 2'd2;

    typedef struct packed {
        logic clr;
        logic ins;
        logic pop;
    } topk_ctrl_t;

endpackage

@@ rtl/core/nuvs_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module nuvs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/nuvs_norm.sv @@
// Query normalizer: scales a vector to Q1.14 with an iterative square root
// and a restoring divider. Depends on nuvs_pkg.
module nuvs_norm
    import nuvs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [QUERY_W-1:0] qx,
    input  logic signed [QUERY_W-1:0] qy,
    input  logic signed [QUERY_W-1:0] qz,
    output logic                      done,
    output logic signed [POS_W-1:0]   nx,
    output logic signed [POS_W-1:0]   ny,
    output logic signed [POS_W-1:0]   nz
);

    localparam int ACC_W = 49;
    localparam int RES_W = 50;
    localparam int RT_W  = 25;
    localparam int DIV_W = 39;
    localparam int QT_W  = 15;

    typedef enum logic [5:0] {
        N_IDLE  = 6'b000001,
        N_SHIFT = 6'b000010,
        N_SQ    = 6'b000100,
        N_ROOT  = 6'b001000,
        N_DIV   = 6'b010000,
        N_DONE  = 6'b100000
    } norm_state_t;

    norm_state_t        state_reg, state_next;
    logic [QUERY_W-1:0] mag_reg [3];
    logic [QUERY_W-1:0] mag_next [3];
    logic [2:0]         neg_reg, neg_next;
    logic [1:0]         sel_reg, sel_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [ACC_W-1:0]   v_reg, v_next;
    logic [RES_W-1:0]   res_reg, res_next;
    logic [ACC_W-1:0]   bit_reg, bit_next;
    logic [RT_W-1:0]    r_reg, r_next;
    logic [DIV_W-1:0]   rem_reg, rem_next;
    logic [DIV_W-1:0]   div_reg, div_next;
    logic [QT_W-1:0]    q_reg, q_next;
    logic [3:0]         step_reg, step_next;
    logic [POS_W-1:0]   n_reg [3];
    logic [POS_W-1:0]   n_next [3];

    logic [QUERY_W-1:0] q_in [3];
    logic [QUERY_W-1:0] sq_mag;
    logic [QUERY_W-1:0] next_mag;
    logic [2*QUERY_W-1:0] sq_prod;
    logic [ACC_W-1:0]   acc_sum;
    logic [RES_W-1:0]   trial;
    logic [RES_W-1:0]   res_new;
    logic               ge;
    logic [QT_W-1:0]    q_fin;
    logic [POS_W-1:0]   n_fin;

    assign q_in[0] = qx;
    assign q_in[1] = qy;
    assign q_in[2] = qz;

    always_comb
    begin
        sq_mag = mag_reg[2];
        next_mag = mag_reg[2];
        case (sel_reg)
            2'd0:
            begin
                sq_mag = mag_reg[0];
                next_mag = mag_reg[1];
            end
            2'd1:
            begin
                sq_mag = mag_reg[1];
                next_mag = mag_reg[2];
            end
            default:
            begin
                sq_mag = mag_reg[2];
                next_mag = mag_reg[2];
            end
        endcase
    end

    assign sq_prod = sq_mag * sq_mag;
    assign acc_sum = acc_reg + ACC_W'(sq_prod);
    assign trial   = res_reg + RES_W'(bit_reg);
    assign ge      = (rem_reg >= div_reg);
    assign q_fin   = {q_reg[QT_W-2:0], ge};
    assign n_fin   = neg_reg[sel_reg] ? (POS_W'(0) - POS_W'(q_fin)) : POS_W'(q_fin);

    always_comb
    begin
        state_next = state_reg;
        mag_next = mag_reg;
        neg_next = neg_reg;
        sel_next = sel_reg;
        acc_next = acc_reg;
        v_next = v_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        r_next = r_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        q_next = q_reg;
        step_next = step_reg;
        n_next = n_reg;
        res_new = res_reg >> 1;
        done = 1'b0;
        unique case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        neg_next[i] = q_in[i][QUERY_W-1];
                        mag_next[i] = q_in[i][QUERY_W-1] ? (~q_in[i] + 1'b1) : q_in[i];
                    end
                    if ((q_in[0] == '0) && (q_in[1] == '0) && (q_in[2] == '0))
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            n_next[i] = '0;
                        end
                        state_next = N_DONE;
                    end
                    else
                    begin
                        state_next = N_SHIFT;
                    end
                end
            end
            N_SHIFT:
            begin
                if (|{mag_reg[0][QUERY_W-1:QUERY_W-2], mag_reg[1][QUERY_W-1:QUERY_W-2],
                      mag_reg[2][QUERY_W-1:QUERY_W-2]})
                begin
                    sel_next = 2'd0;
                    acc_next = '0;
                    state_next = N_SQ;
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_next[i] = {mag_reg[i][QUERY_W-2:0], 1'b0};
                    end
                end
            end
            N_SQ:
            begin
                acc_next = acc_sum;
                sel_next = sel_reg + 2'd1;
                if (sel_reg == 2'd2)
                begin
                    v_next = acc_sum;
                    res_next = '0;
                    bit_next = ACC_W'(1) << (ACC_W - 1);
                    state_next = N_ROOT;
                end
            end
            N_ROOT:
            begin
                if ({1'b0, v_reg} >= trial)
                begin
                    v_next = v_reg - trial[ACC_W-1:0];
                    res_new = (res_reg >> 1) + RES_W'(bit_reg);
                end
                res_next = res_new;
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    r_next = res_new[RT_W-1:0];
                    sel_next = 2'd0;
                    step_next = 4'(QT_W - 1);
                    q_next = '0;
                    rem_next = DIV_W'({mag_reg[0], 14'b0}) + DIV_W'(res_new[RT_W-1:1]);
                    div_next = DIV_W'({res_new[RT_W-1:0], 14'b0});
                    state_next = N_DIV;
                end
            end
            N_DIV:
            begin
                rem_next = ge ? (rem_reg - div_reg) : rem_reg;
                div_next = div_reg >> 1;
                q_next = q_fin;
                step_next = step_reg - 4'd1;
                if (step_reg == 4'd0)
                begin
                    case (sel_reg)
                        2'd0: n_next[0] = n_fin;
                        2'd1: n_next[1] = n_fin;
                        default: n_next[2] = n_fin;
                    endcase
                    if (sel_reg == 2'd2)
                    begin
                        state_next = N_DONE;
                    end
                    else
                    begin
                        sel_next = sel_reg + 2'd1;
                        step_next = 4'(QT_W - 1);
                        q_next = '0;
                        rem_next = DIV_W'({next_mag, 14'b0}) + DIV_W'(r_reg[RT_W-1:1]);
                        div_next = DIV_W'({r_reg, 14'b0});
                    end
                end
            end
            N_DONE:
            begin
                done = 1'b1;
                state_next = N_IDLE;
            end
            default:
            begin
                state_next = N_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        sel_reg <= sel_next;
        acc_reg <= acc_next;
        v_reg <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
        r_reg <= r_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        q_reg <= q_next;
        step_reg <= step_next;
        n_reg <= n_next;
    end

    assign nx = n_reg[0];
    assign ny = n_reg[1];
    assign nz = n_reg[2];

endmodule

@@ rtl/core/nuvs_topk.sv @@
// Sorted list of the closest candidates seen so far, one insertion per cycle.
// Depends on nuvs_pkg.
module nuvs_topk
    import nuvs_pkg::*;
#(
    parameter int MAX_K = MAX_K_DEF,
    parameter int IDX_W = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  topk_ctrl_t                   ctrl,
    input  logic [$clog2(MAX_K+1)-1:0]   k,
    input  logic [IDX_W-1:0]             cand_idx,
    input  logic [DIST_W-1:0]            cand_dist,
    output logic [IDX_W-1:0]             head_idx
);

    localparam int KW = $clog2(MAX_K + 1);

    logic [KW-1:0]     used_reg, used_next;
    logic [DIST_W-1:0] dist_reg [MAX_K];
    logic [DIST_W-1:0] dist_next [MAX_K];
    logic [IDX_W-1:0]  idx_reg [MAX_K];
    logic [IDX_W-1:0]  idx_next [MAX_K];
    logic [MAX_K-1:0]  lt;
    logic [MAX_K:0]    lt_ext;

    always_comb
    begin
        for (int j = 0; j < MAX_K; j++)
        begin
            lt[j] = (KW'(j) < k) && ((KW'(j) >= used_reg) || (cand_dist < dist_reg[j]));
        end
    end

    assign lt_ext = {lt, 1'b0};

    always_comb
    begin
        used_next = used_reg;
        dist_next = dist_reg;
        idx_next = idx_reg;
        if (ctrl.clr)
        begin
            used_next = '0;
        end
        else if (ctrl.ins)
        begin
            for (int j = 0; j < MAX_K; j++)
            begin
                if (lt[j])
                begin
                    if (lt_ext[j])
                    begin
                        dist_next[j] = dist_reg[(j > 0) ? j - 1 : 0];
                        idx_next[j] = idx_reg[(j > 0) ? j - 1 : 0];
                    end
                    else
                    begin
                        dist_next[j] = cand_dist;
                        idx_next[j] = cand_idx;
                    end
                end
            end
            if (used_reg < k)
            begin
                used_next = used_reg + 1'b1;
            end
        end
        else if (ctrl.pop)
        begin
            for (int j = 0; j < MAX_K - 1; j++)
            begin
                dist_next[j] = dist_reg[j+1];
                idx_next[j] = idx_reg[j+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
        idx_reg <= idx_next;
    end

    assign head_idx = idx_reg[0];

endmodule

@@ rtl/core/nearest_unit_vector_search_top.sv @@
// Top level of the nearest unit-vector search block.
// Depends on nuvs_pkg, nuvs_ram, nuvs_norm and nuvs_topk.
//
// Usage: the input stream carries one request per transfer; tuser holds the
// request kind (load, nearest, k closest). A load writes one table entry and
// gives no output. A search normalizes the query (shift, square, root and
// divide steps), then reads entries 0 .. cell_count-1 (capped at MAX_CELLS)
// from the table memory, one entry per cycle through a four-stage distance
// pipeline. Results leave on the output stream nearest first, tlast on the
// final one, tuser as the found flag; a search with a zero result count sends
// one transfer with found low. One request is in work at a time; the input is
// ready again as soon as the final result sits in the output register, even
// while the receiver stalls. A stalled receiver holds the block in result
// emission. Reset clears the state machines, valid flags, emission count and
// cell_count; table entries are undefined until loaded. The user writes
// cell_count through cfg_wr_en/cfg_wr_data only while the block idles; the
// block itself does not enforce this.
module nearest_unit_vector_search_top
    import nuvs_pkg::*;
#(
    parameter int MAX_CELLS = MAX_CELLS_DEF,
    parameter int MAX_K     = MAX_K_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [10:0]  cfg_wr_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // cell_index, pos_x, pos_y, pos_z, query_x, query_y, query_z, want_count
    input  logic [143:0] s_axis_tdata,
    // req_type
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_cell
    output logic [15:0]  m_axis_tdata,
    // found
    output logic [0:0]   m_axis_tuser,
    output logic         m_axis_tlast
);

    localparam int AW = $clog2(MAX_CELLS);
    localparam int CW = $clog2(MAX_CELLS + 1);
    localparam int KW = $clog2(MAX_K + 1);
    localparam int EW = 18;
    localparam int DW = 3 * POS_W + 2;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_NORM  = 5'b00010,
        S_WALK  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_EMIT  = 5'b10000
    } top_state_t;

    top_state_t  state_reg, state_next;
    logic [10:0] cell_count_reg, cell_count_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [KW-1:0] k_reg, k_next;
    logic [KW-1:0] emit_cnt_reg, emit_cnt_next;
    logic          empty_reg, empty_next;
    logic [CW-1:0] walk_reg, walk_next;
    logic          rd_v_reg, rd_v_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic          s2_v_reg, s2_v_next;
    logic [AW-1:0] s2_idx_reg;
    logic signed [POS_W+1:0] dx_reg, dy_reg, dz_reg;
    logic          s3_v_reg, s3_v_next;
    logic [AW-1:0] s3_idx_reg;
    logic [SQ_W-1:0] sqx_reg, sqy_reg, sqz_reg;
    logic          m_valid_reg, m_valid_next;
    logic [9:0]    out_cell_reg, out_cell_next;
    logic          out_found_reg, out_found_next;
    logic          out_last_reg, out_last_next;

    logic          accept;
    logic [1:0]    req;
    logic [EW-1:0] idx_ext;
    logic [EW-1:0] cnt_ext;
    logic [EW-1:0] kreq_ext;
    logic [CW-1:0] cnt_eff;
    logic          ram_we;
    logic          ram_re;
    logic [3*POS_W-1:0] ram_rdata;
    logic          norm_start;
    logic          norm_done;
    logic signed [POS_W-1:0] nx, ny, nz;
    logic signed [POS_W-1:0] tx, ty, tz;
    logic signed [2*(POS_W+2)-1:0] px, py, pz;
    logic [DIST_W-1:0] dist_sum;
    topk_ctrl_t    tk_ctrl;
    logic [AW-1:0] head_idx;
    logic [16:0]   head_ext;

    assign req     = s_axis_tuser;
    assign accept  = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign idx_ext = EW'(s_axis_tdata[9:0]);
    assign ram_we  = accept && (req == REQ_LOAD) && (idx_ext < EW'(MAX_CELLS));
    assign norm_start = accept && ((req == REQ_NEAREST) || (req == REQ_KNN));

    assign cnt_eff = (EW'(cell_count_reg) > EW'(MAX_CELLS)) ? CW'(MAX_CELLS)
                                                             : CW'(cell_count_reg);
    assign cnt_ext = EW'(cnt_eff);

    always_comb
    begin
        if (req == REQ_NEAREST)
        begin
            kreq_ext = EW'(1);
        end
        else if (EW'(s_axis_tdata[137:130]) > EW'(MAX_K))
        begin
            kreq_ext = EW'(MAX_K);
        end
        else
        begin
            kreq_ext = EW'(s_axis_tdata[137:130]);
        end
    end

    nuvs_ram #(
        .WIDTH (3 * POS_W),
        .DEPTH (MAX_CELLS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_ext[AW-1:0]),
        .wdata (s_axis_tdata[57:10]),
        .re    (ram_re),
        .raddr (walk_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    nuvs_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .qx    (s_axis_tdata[81:58]),
        .qy    (s_axis_tdata[105:82]),
        .qz    (s_axis_tdata[129:106]),
        .done  (norm_done),
        .nx    (nx),
        .ny    (ny),
        .nz    (nz)
    );

    assign tx = ram_rdata[POS_W-1:0];
    assign ty = ram_rdata[2*POS_W-1:POS_W];
    assign tz = ram_rdata[3*POS_W-1:2*POS_W];

    assign px = dx_reg * dx_reg;
    assign py = dy_reg * dy_reg;
    assign pz = dz_reg * dz_reg;

    assign dist_sum = DIST_W'(sqx_reg) + DIST_W'(sqy_reg) + DIST_W'(sqz_reg);

    nuvs_topk #(
        .MAX_K (MAX_K),
        .IDX_W (AW)
    ) u_topk (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (tk_ctrl),
        .k         (k_reg),
        .cand_idx  (s3_idx_reg),
        .cand_dist (dist_sum),
        .head_idx  (head_idx)
    );

    assign head_ext = 17'(head_idx);

    always_comb
    begin
        state_next = state_reg;
        cell_count_next = cell_count_reg;
        cnt_next = cnt_reg;
        k_next = k_reg;
        emit_cnt_next = emit_cnt_reg;
        empty_next = empty_reg;
        walk_next = walk_reg;
        rd_v_next = 1'b0;
        rd_idx_next = rd_idx_reg;
        s2_v_next = rd_v_reg;
        s3_v_next = s2_v_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        out_cell_next = out_cell_reg;
        out_found_next = out_found_reg;
        out_last_next = out_last_reg;
        ram_re = 1'b0;
        tk_ctrl = '0;
        tk_ctrl.ins = s3_v_reg;
        if (cfg_wr_en)
        begin
            cell_count_next = cfg_wr_data;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (norm_start)
                begin
                    cnt_next = cnt_eff;
                    k_next = (kreq_ext > cnt_ext) ? KW'(cnt_ext) : KW'(kreq_ext);
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                if (norm_done)
                begin
                    walk_next = '0;
                    if (k_reg == '0)
                    begin
                        emit_cnt_next = KW'(1);
                        empty_next = 1'b1;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        emit_cnt_next = k_reg;
                        empty_next = 1'b0;
                        tk_ctrl.clr = 1'b1;
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                ram_re = 1'b1;
                rd_v_next = 1'b1;
                rd_idx_next = walk_reg[AW-1:0];
                walk_next = walk_reg + 1'b1;
                if (walk_reg == cnt_reg - 1'b1)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!rd_v_reg && !s2_v_reg && !s3_v_reg)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    out_cell_next = empty_reg ? 10'd0 : head_ext[9:0];
                    out_found_next = !empty_reg;
                    out_last_next = (emit_cnt_reg == KW'(1));
                    tk_ctrl.pop = !empty_reg;
                    emit_cnt_next = emit_cnt_reg - 1'b1;
                    if (emit_cnt_reg == KW'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cell_count_reg <= '0;
            rd_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            emit_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cell_count_reg <= cell_count_next;
            rd_v_reg <= rd_v_next;
            s2_v_reg <= s2_v_next;
            s3_v_reg <= s3_v_next;
            m_valid_reg <= m_valid_next;
            emit_cnt_reg <= emit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        k_reg <= k_next;
        empty_reg <= empty_next;
        walk_reg <= walk_next;
        rd_idx_reg <= rd_idx_next;
        s2_idx_reg <= rd_idx_reg;
        dx_reg <= (POS_W+2)'(nx) - (POS_W+2)'(tx);
        dy_reg <= (POS_W+2)'(ny) - (POS_W+2)'(ty);
        dz_reg <= (POS_W+2)'(nz) - (POS_W+2)'(tz);
        s3_idx_reg <= s2_idx_reg;
        sqx_reg <= px[SQ_W-1:0];
        sqy_reg <= py[SQ_W-1:0];
        sqz_reg <= pz[SQ_W-1:0];
        out_cell_reg <= out_cell_next;
        out_found_reg <= out_found_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {6'b0, out_cell_reg};
    assign m_axis_tuser  = out_found_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_norm_done_in_norm: assert property (@(posedge clk) disable iff (!rst_n)
        norm_done |-> (state_reg == S_NORM))
        else $error("normalizer finished outside the normalize phase");

    a_insert_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        s3_v_reg |-> ((state_reg == S_WALK) || (state_reg == S_DRAIN)))
        else $error("distance pipeline active outside the table walk");

    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (emit_cnt_reg != '0))
        else $error("result emission with nothing left to send");

    a_last_ends_query: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EMIT) && (!m_valid_reg || m_axis_tready) && (emit_cnt_reg == KW'(1)))
        |=> (m_axis_tlast && (state_reg == S_IDLE)))
        else $error("final result did not end the query");
`endif

endmodule

@@ sim/tb_nearest_unit_vector_search_top.sv @@
// Testbench for nearest_unit_vector_search_top: loads cell tables, runs nearest and k-closest
// searches under random stalls on both streams, and checks every result transfer against
// an internal predictor. Depends on nuvs_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_nearest_unit_vector_search_top;
    import nuvs_pkg::*;

    localparam int TABLE_DEPTH = 1024;
    localparam int K_LIMIT = 8;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        bit              is_cfg;
        logic [10:0]     cfg_value;
        logic [1:0]      req;
        logic [9:0]      idx;
        logic [15:0]     px;
        logic [15:0]     py;
        logic [15:0]     pz;
        logic [23:0]     qx;
        logic [23:0]     qy;
        logic [23:0]     qz;
        logic [7:0]      want;
    } request_t;

    typedef struct {
        logic [9:0] cell_id;
        logic        found;
        logic        last;
    } hit_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_wr_en;
    logic [10:0]  cfg_wr_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [15:0]  m_axis_tdata;
    logic [0:0]   m_axis_tuser;
    logic         m_axis_tlast;

    request_t pending_reqs[$];
    hit_t     expected_hits[$];
    request_t cur_req;

    int        tbl_x[TABLE_DEPTH];
    int        tbl_y[TABLE_DEPTH];
    int        tbl_z[TABLE_DEPTH];
    int        active_cells;
    bit        written[TABLE_DEPTH];
    int        filled;

    int  errors;
    int  n_loads;
    int  n_searches;
    int  n_hits;
    int  idle_cycles;
    int  send_gap;
    int  settle;
    bit  send_burst;
    int  recv_stall;
    int  holdoff;
    bit  holdoff_done;
    bit  s_took;
    bit  m_took;

    nearest_unit_vector_search_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    task automatic unit_query(input logic [23:0] q[3], output longint n[3]);
        longint unsigned mag[3];
        longint unsigned mx;
        longint unsigned sum;
        longint unsigned r;
        longint unsigned qv;
        bit neg[3];
        mx = 0;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = q[i][23];
            mag[i] = neg[i] ? (64'h1000000 - q[i]) : q[i];
            if (mag[i] > mx)
                mx = mag[i];
        end
        if (mx == 0)
        begin
            n[0] = 0;
            n[1] = 0;
            n[2] = 0;
            return;
        end
        while (mx < (64'd1 << 22))
        begin
            mx <<= 1;
            for (int i = 0; i < 3; i++)
                mag[i] <<= 1;
        end
        for (int i = 0; i < 3; i++)
            sum += mag[i] * mag[i];
        r = int_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            qv = (mag[i] * 16384 + (r >> 1)) / r;
            n[i] = neg[i] ? -longint'(qv) : longint'(qv);
        end
    endtask

    function automatic longint unsigned cell_dist(longint n[3], int i);
        longint dx;
        longint dy;
        longint dz;
        dx = n[0] - tbl_x[i];
        dy = n[1] - tbl_y[i];
        dz = n[2] - tbl_z[i];
        return dx * dx + dy * dy + dz * dz;
    endfunction

    task automatic predict_search(input request_t rq);
        logic [23:0]     q[3];
        longint          n[3];
        int              cnt;
        int              k;
        int              used;
        int              pos;
        int              best;
        longint unsigned d;
        longint unsigned bd;
        int              lidx[K_LIMIT];
        longint unsigned ldist[K_LIMIT];
        hit_t            h;
        q[0] = rq.qx;
        q[1] = rq.qy;
        q[2] = rq.qz;
        cnt = (active_cells > TABLE_DEPTH) ? TABLE_DEPTH : active_cells;
        unit_query(q, n);
        k = (rq.req == REQ_NEAREST) ? 1 : int'(rq.want);
        if (k > K_LIMIT)
            k = K_LIMIT;
        if (k > cnt)
            k = cnt;
        if (k == 0)
        begin
            h.cell_id = 0;
            h.found = 0;
            h.last = 1;
            expected_hits.push_back(h);
            return;
        end
        if (rq.req == REQ_NEAREST)
        begin
            best = 0;
            bd = 0;
            for (int i = 0; i < cnt; i++)
            begin
                d = cell_dist(n, i);
                if (i == 0 || d < bd)
                begin
                    bd = d;
                    best = i;
                end
            end
            h.cell_id = 10'(best);
            h.found = 1;
            h.last = 1;
            expected_hits.push_back(h);
            return;
        end
        used = 0;
        for (int i = 0; i < cnt; i++)
        begin
            d = cell_dist(n, i);
            pos = used;
            while (pos > 0 && d < ldist[pos - 1])
                pos--;
            if (pos < k)
            begin
                for (int j = (used < k) ? used : k - 1; j > pos; j--)
                begin
                    lidx[j] = lidx[j - 1];
                    ldist[j] = ldist[j - 1];
                end
                lidx[pos] = i;
                ldist[pos] = d;
                if (used < k)
                    used++;
            end
        end
        for (int i = 0; i < k; i++)
        begin
            h.cell_id = 10'(lidx[i]);
            h.found = 1;
            h.last = (i + 1 == k);
            expected_hits.push_back(h);
        end
    endtask

    // Model update and result checking, all at the rising edge.
    always @(posedge clk)
    begin
        s_took <= s_axis_tvalid && s_axis_tready;
        m_took <= m_axis_tvalid && m_axis_tready;
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (m_axis_tvalid && m_axis_tready)
            begin
                n_hits++;
                if (expected_hits.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result cell %0d found %0b last %0b", $time,
                             m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end
                else
                begin
                    hit_t e;
                    e = expected_hits.pop_front();
                    if (m_axis_tdata !== {6'd0, e.cell_id} || m_axis_tuser[0] !== e.found
                        || m_axis_tlast !== e.last)
                    begin
                        errors++;
                        $display("%0t: expected cell %0d found %0b last %0b, got cell %0d found %0b last %0b",
                                 $time, e.cell_id, e.found, e.last, m_axis_tdata, m_axis_tuser,
                                 m_axis_tlast);
                    end
                end
            end
            if (cfg_wr_en)
                active_cells = cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (cur_req.req == REQ_LOAD)
                begin
                    n_loads++;
                    tbl_x[cur_req.idx] = $signed(cur_req.px);
                    tbl_y[cur_req.idx] = $signed(cur_req.py);
                    tbl_z[cur_req.idx] = $signed(cur_req.pz);
                end
                else if (cur_req.req == REQ_NEAREST || cur_req.req == REQ_KNN)
                begin
                    n_searches++;
                    predict_search(cur_req);
                end
            end
        end
    end

    // Request driver; register writes wait until all results are back.
    always @(negedge clk)
    begin
        logic nv;
        logic ncfg;
        nv = s_axis_tvalid;
        ncfg = 1'b0;
        if (rst_n)
        begin
            if (s_took)
                nv = 1'b0;
            if (!nv)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_reqs.size() > 0)
                begin
                    if (pending_reqs[0].is_cfg)
                    begin
                        if (expected_hits.size() != 0)
                            settle = 0;
                        else if (settle < 24)
                            settle++;
                        else
                        begin
                            settle = 0;
                            cfg_wr_data <= pending_reqs[0].cfg_value;
                            ncfg = 1'b1;
                            void'(pending_reqs.pop_front());
                        end
                    end
                    else
                    begin
                        cur_req = pending_reqs.pop_front();
                        s_axis_tdata <= {6'd0, cur_req.want, cur_req.qz, cur_req.qy,
                                         cur_req.qx, cur_req.pz, cur_req.py, cur_req.px,
                                         cur_req.idx};
                        s_axis_tuser <= cur_req.req;
                        nv = 1'b1;
                        if ($urandom_range(0, 19) == 0)
                            send_burst = !send_burst;
                        send_gap = send_burst ? 0 : $urandom_range(0, 15);
                    end
                end
            end
        end
        s_axis_tvalid <= nv;
        cfg_wr_en <= ncfg;
    end

    // Result receiver with random stalls and one long hold-off.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_took)
            begin
                recv_stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
                if (!holdoff_done && n_hits >= 40)
                begin
                    holdoff_done = 1;
                    holdoff = 400;
                end
            end
            if (holdoff > 0)
            begin
                holdoff--;
                m_axis_tready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb_nearest_unit_vector_search_top: errors");
            $finish;
        end
    end

    function automatic logic [15:0] rand_pos();
        case ($urandom_range(0, 5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'd0;
            default: return 16'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    function automatic logic [23:0] rand_query();
        case ($urandom_range(0, 7))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'd0;
            3: return 24'($signed($urandom_range(0, 64)) - 32);
            default: return 24'($urandom());
        endcase
    endfunction

    task automatic push_cfg(input int v);
        request_t r;
        r = '{default: 0};
        r.is_cfg = 1;
        r.cfg_value = 11'(v);
        pending_reqs.push_back(r);
    endtask

    task automatic push_load(input int idx, input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z);
        request_t r;
        r = '{default: 0};
        r.req = REQ_LOAD;
        r.idx = 10'(idx);
        r.px = x;
        r.py = y;
        r.pz = z;
        r.qx = 24'($urandom());
        r.want = 8'($urandom());
        pending_reqs.push_back(r);
        written[idx] = 1;
        while (filled < TABLE_DEPTH && written[filled])
            filled++;
    endtask

    task automatic push_search(input logic [1:0] kind, input logic [23:0] x,
                               input logic [23:0] y, input logic [23:0] z, input int want);
        request_t r;
        r = '{default: 0};
        r.req = kind;
        r.idx = 10'($urandom());
        r.px = 16'($urandom());
        r.qx = x;
        r.qy = y;
        r.qz = z;
        r.want = 8'(want);
        pending_reqs.push_back(r);
    endtask

    initial
    begin
        int sel;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        errors = 0;
        n_loads = 0;
        n_searches = 0;
        n_hits = 0;
        idle_cycles = 0;
        send_gap = 0;
        settle = 0;
        send_burst = 0;
        recv_stall = 0;
        holdoff = 0;
        holdoff_done = 0;
        active_cells = 0;
        filled = 0;

        // Empty table, unused request kind, then axis-aligned entries with a duplicate.
        push_search(REQ_NEAREST, 24'd5, 24'd0, 24'd0, 0);
        push_search(REQ_KNN, 24'd5, 24'd0, 24'd0, 3);
        push_search(2'd3, 24'h7FFFFF, 24'h800000, 24'd1, 255);
        push_load(0, 16'sd16384, 16'd0, 16'd0);
        push_load(1, -16'sd16384, 16'd0, 16'd0);
        push_load(2, 16'd0, 16'sd16384, 16'd0);
        push_load(3, 16'd0, -16'sd16384, 16'd0);
        push_load(4, 16'd0, 16'd0, 16'sd16384);
        push_load(5, 16'd0, 16'd0, -16'sd16384);
        push_load(6, 16'sd16384, 16'd0, 16'd0);
        push_cfg(7);
        push_search(REQ_NEAREST, 24'd0, 24'd0, 24'd0, 0);
        push_search(REQ_KNN, 24'd0, 24'd0, 24'd0, 255);
        push_search(REQ_NEAREST, 24'd1, 24'd0, 24'd0, 0);
        push_search(REQ_KNN, 24'h7FFFFF, 24'd0, 24'd0, 3);
        push_search(REQ_KNN, 24'h800000, 24'h800000, 24'h800000, 8);
        push_search(REQ_NEAREST, 24'd0, 24'h7FFFFF, 24'h800000, 0);
        push_search(REQ_KNN, 24'd3, 24'd3, 24'd3, 0);
        push_search(REQ_KNN, 24'hFFFFFF, 24'd0, 24'd0, 2);

        for (int i = 7; i < 48; i++)
            push_load(i, rand_pos(), rand_pos(), rand_pos());

        for (int blk = 0; blk < 6; blk++)
        begin
            sel = $urandom_range(0, 3);
            push_cfg(sel == 0 ? filled : (sel == 1 ? 1 : $urandom_range(0, filled)));
            for (int j = 0; j < 33; j++)
            begin
                sel = $urandom_range(0, 19);
                if (sel < 5)
                    push_load(sel == 0 ? $urandom_range(0, 1023) : $urandom_range(0, filled),
                              rand_pos(), rand_pos(), rand_pos());
                else if (sel == 5)
                    push_search(2'd3, rand_query(), rand_query(), rand_query(), 1);
                else if (sel < 11)
                    push_search(REQ_NEAREST, rand_query(), rand_query(), rand_query(),
                                $urandom_range(0, 255));
                else
                    push_search(REQ_KNN, rand_query(), rand_query(), rand_query(),
                                $urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                          : $urandom_range(0, 9));
            end
        end

        // Cell count up to the first unloaded entry, then a zero count.
        push_cfg(filled);
        push_search(REQ_KNN, rand_query(), rand_query(), rand_query(), 200);
        push_search(REQ_NEAREST, rand_query(), rand_query(), rand_query(), 0);
        push_cfg(0);
        push_search(REQ_KNN, rand_query(), rand_query(), rand_query(), 8);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_reqs.size() == 0 && !s_axis_tvalid && expected_hits.size() == 0);
        repeat (200) @(posedge clk);
        $display("Covered %0d table loads and %0d searches, %0d result transfers checked.",
                 n_loads, n_searches, n_hits);
        $display("Cell counts from zero up to the loaded table, with stalls and a long hold-off.");
        if (errors == 0 && expected_hits.size() == 0)
            $display("tb_nearest_unit_vector_search_top: clean");
        else
            $display("tb_nearest_unit_vector_search_top: errors");
        $finish;
    end

endmodule
